// File: sv/hme_pkg.sv
// shared types and constants for the hash map engine
`timescale 1ns / 1ps
package hme_pkg;
    localparam int BucketCount = 769;
    localparam int SlotsPerBucket = 4;
    localparam int RowAw = $clog2(BucketCount);
    localparam int KeyW = 31;
    localparam int ValW = 32;
    localparam int SlotW = 1 + KeyW + ValW;
    localparam int RowW = SlotsPerBucket * SlotW;
    localparam int SlotIw = (SlotsPerBucket > 1) ? $clog2(SlotsPerBucket) : 1;
    // reciprocal for key / BucketCount, exact for 31-bit keys
    localparam int RecipShift = 31 + RowAw;
    localparam int RecipW = 32;
    localparam logic [RecipW-1:0] RecipMul =
        RecipW'(((64'd1 << RecipShift) + 64'(BucketCount) - 64'd1) / 64'(BucketCount));

    localparam logic [1:0] MODE_PUT = 2'd0;
    localparam logic [1:0] MODE_GET = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic load;     // capture request, compute bucket
        logic rd;       // issue row read
        logic eval;     // compare row, write back, register result
    } hme_cmd_t;

    typedef struct packed {
        logic clear_done;
    } hme_sts_t;
endpackage

// File: sv/hash_map_engine_top.sv
// top level of the hash map engine
// usage:
//   requests arrive on the s_ stream: tuser carries the mode (put, get,
//   remove), tdata the key in bits 30:0 and the value in bits 62:31
//   one result beat per request leaves on the m_ stream: tdata holds
//   found, the read value and the overflow flag
//   the table has 769 buckets of 4 slots; a bucket is one memory row
//   holding valid, key and value of all its slots
// timing:
//   the result beat follows its request beat through three states: hash in
//   the accepting cycle, row read, then compare and write back, where the
//   result is registered; the single row port and the three-state sequence
//   set the rate: the next request is taken only after the last left compare
//   a waiting result does not block the next request; a stalled receiver
//   holds the finished result and the engine waits in compare
// reset:
//   after aresetn the rows are cleared one per cycle, all 769 of them,
//   during which s_tready stays low
//   mode 3 returns an all-zero result and leaves the table untouched
`timescale 1ns / 1ps
module hash_map_engine_top import hme_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key[30:0], value[62:31], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // found[0], read_value[32:1], overflow[33], zero pad
);
    hme_cmd_t        cmd;
    hme_sts_t        sts;
    logic            found;
    logic [ValW-1:0] read_value;
    logic            overflow;

    hme_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .sts(sts),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .cmd(cmd)
    );

    hme_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .mode(s_tuser), .key(s_tdata[KeyW-1:0]),
        .value(s_tdata[KeyW +: ValW]),
        .found(found), .read_value(read_value), .overflow(overflow)
    );

    assign m_tdata = {6'd0, overflow, read_value, found};
endmodule

// File: sv/hme_datapath.sv
// row memory, bucket hash, slot compare and write back
`timescale 1ns / 1ps
module hme_datapath import hme_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  hme_cmd_t        cmd,
    output hme_sts_t        sts,
    input  logic [1:0]      mode,
    input  logic [KeyW-1:0] key,
    input  logic [ValW-1:0] value,
    output logic            found,
    output logic [ValW-1:0] read_value,
    output logic            overflow
);
    logic [RowW-1:0]  mem [BucketCount];
    logic [RowW-1:0]  row_reg;
    logic [1:0]       mode_reg;
    logic [KeyW-1:0]  key_reg;
    logic [ValW-1:0]  value_reg;
    logic [RowAw-1:0] addr_reg;
    logic [RowAw-1:0] clr_reg;
    logic             clr_busy_reg;
    logic [KeyW+RecipW-1:0] prod;
    logic [RowAw-1:0] quo;
    logic [RowAw-1:0] rem;
    logic [SlotsPerBucket-1:0] hit_vec, free_vec;
    logic [SlotIw-1:0] hit_idx, free_idx;
    logic             hit, has_free;
    logic [RowW-1:0]  new_row;
    logic             wr;
    logic [SlotW-1:0] slot;

    // key mod bucket count by reciprocal multiply, remainder in low bits only
    assign prod = (KeyW+RecipW)'(key) * (KeyW+RecipW)'(RecipMul);
    assign quo = RowAw'(prod >> RecipShift);
    assign rem = RowAw'(key) - RowAw'(quo * RowAw'(BucketCount));

    always_comb begin
        hit_vec = '0;
        free_vec = '0;
        hit_idx = '0;
        free_idx = '0;
        for (int s = SlotsPerBucket - 1; s >= 0; s--) begin
            slot = row_reg[s*SlotW +: SlotW];
            hit_vec[s] = slot[SlotW-1] && slot[ValW +: KeyW] == key_reg;
            free_vec[s] = !slot[SlotW-1];
            if (hit_vec[s]) hit_idx = SlotIw'(s);
            if (free_vec[s]) free_idx = SlotIw'(s);
        end
        hit = |hit_vec;
        has_free = |free_vec;
        new_row = row_reg;
        wr = 1'b0;
        case (mode_reg)
            MODE_PUT: begin
                if (hit) begin
                    new_row[hit_idx*SlotW +: ValW] = value_reg;
                    wr = 1'b1;
                end else if (has_free) begin
                    new_row[free_idx*SlotW +: SlotW] = {1'b1, key_reg, value_reg};
                    wr = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (hit) begin
                    new_row[hit_idx*SlotW + SlotW - 1] = 1'b0;
                    wr = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= mode;
            key_reg <= key;
            value_reg <= value;
            addr_reg <= rem;
        end
        if (cmd.rd) row_reg <= mem[addr_reg];
        if (clr_busy_reg) mem[clr_reg] <= '0;
        else if (cmd.eval && wr) mem[addr_reg] <= new_row;
        if (cmd.eval) begin
            found <= hit && mode_reg != MODE_UNUSED;
            read_value <= (mode_reg == MODE_GET && hit)
                        ? row_reg[hit_idx*SlotW +: ValW] : '0;
            overflow <= mode_reg == MODE_PUT && !hit && !has_free;
        end
    end

    // clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end else if (clr_busy_reg) begin
            if (clr_reg == RowAw'(BucketCount - 1)) clr_busy_reg <= 1'b0;
            clr_reg <= clr_reg + 1'b1;
        end
    end
    assign sts.clear_done = !clr_busy_reg;
endmodule

// File: sv/hme_ctrl.sv
// request sequencer for the hash map engine
`timescale 1ns / 1ps
module hme_ctrl import hme_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  hme_sts_t sts,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output hme_cmd_t cmd
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EVAL = 3'b100
    } state_t;
    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    // a new request may enter while the previous result waits; it is then
    // held in eval until that result leaves
    assign s_tready = state_reg == ST_IDLE && sts.clear_done;
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next = state_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd = '0;
        case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready) begin
                cmd.load = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.rd = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: if (!mvalid_reg || m_tready) begin
                cmd.eval = 1'b1;
                mvalid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule

// File: verif/testbench.sv
// self-checking testbench for the hash map engine: predicts each result beat from a local table
`timescale 1ns / 1ps
module testbench import hme_pkg::*;;

    localparam int IdleLimit = 20000;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        overflow;
    } lookup_result_t;

    // local copy of the table and the queue of predicted result beats
    class hash_map_scoreboard;
        bit          valid_q [BucketCount*SlotsPerBucket];
        bit [30:0]   key_q   [BucketCount*SlotsPerBucket];
        bit [31:0]   value_q [BucketCount*SlotsPerBucket];
        lookup_result_t pending_results[$];
        int errors;

        function void note_request(logic [1:0] mode, logic [30:0] key, logic [31:0] value);
            int base;
            int hit;
            int free_idx;
            lookup_result_t r;
            base = (key % BucketCount) * SlotsPerBucket;
            hit = -1;
            free_idx = -1;
            r = '0;
            for (int s = 0; s < SlotsPerBucket; s++) begin
                if (hit < 0 && valid_q[base+s] && key_q[base+s] == key) hit = base + s;
                if (free_idx < 0 && !valid_q[base+s]) free_idx = base + s;
            end
            if (mode != MODE_UNUSED) r.found = (hit >= 0);
            case (mode)
                MODE_PUT: begin
                    if (hit >= 0) value_q[hit] = value;
                    else if (free_idx >= 0) begin
                        valid_q[free_idx] = 1'b1;
                        key_q[free_idx] = key;
                        value_q[free_idx] = value;
                    end else r.overflow = 1'b1;
                end
                MODE_GET: if (hit >= 0) r.read_value = value_q[hit];
                MODE_REMOVE: if (hit >= 0) valid_q[hit] = 1'b0;
                default: ;
            endcase
            pending_results = {pending_results, r};
        endfunction

        function void check_result(logic [39:0] beat);
            lookup_result_t e;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending: %h", beat);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (beat[0] !== e.found) begin
                $error("found: expected %0d, got %0d", e.found, beat[0]);
                errors++;
            end
            if (beat[32:1] !== e.read_value) begin
                $error("read_value: expected %h, got %h", e.read_value, beat[32:1]);
                errors++;
            end
            if (beat[33] !== e.overflow) begin
                $error("overflow: expected %0d, got %0d", e.overflow, beat[33]);
                errors++;
            end
            if (beat[39:34] !== '0) begin
                $error("pad: expected 0, got %h", beat[39:34]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    hash_map_scoreboard sb = new();
    int send_idle_pct = 0;     // chance in percent that the sender idles a cycle
    int recv_stall_pct = 0;    // chance in percent that the receiver stalls a cycle
    bit hold_off = 1'b0;       // long receiver hold-off in progress
    bit hold_req = 1'b0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;

    // 16 keys that all collide in one bucket so its row fills up
    logic [30:0] hot_keys[16];

    always #5 aclk = ~aclk;

    hash_map_engine_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // sample both handshakes at the edge, predictions before checks
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata[30:0], s_tdata[62:31]);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog: long stretch with no accepted beat on either side
    always @(posedge aclk) begin
        if (idle_cycles >= IdleLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("hash_map_engine_top regression: fail");
            $finish;
        end
    end

    // receiver ready, random stalls or a long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // long hold-off counted here while the sender keeps offering beats
    always @(posedge aclk) begin
        if (hold_req && !hold_off) begin
            hold_off = 1'b1;
            repeat (300) @(posedge aclk);
            hold_off = 1'b0;
            hold_req = 1'b0;
        end
    end

    // one request beat, held until accepted; valid only dropped on an idle cycle
    task automatic send_request(logic [1:0] mode, logic [30:0] key, logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {1'b0, value, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic pick_key(output logic [30:0] key);
        case ($urandom_range(3))
            0: key = hot_keys[4'($urandom_range(15))];
            1: key = 31'($urandom_range(3) * BucketCount + $urandom_range(1));
            2: key = 31'($urandom());
            default: key = 31'($urandom_range(40));
        endcase
    endtask

    task automatic run_random(int count);
        logic [30:0] key;
        logic [1:0]  mode;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick_key(key);
            pick = $urandom_range(99);
            mode = pick < 45 ? MODE_PUT : pick < 75 ? MODE_GET :
                   pick < 97 ? MODE_REMOVE : MODE_UNUSED;
            send_request(mode, key, $urandom());
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain;
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < 16; i++)
            hot_keys[i] = 31'((i / 8) * BucketCount * 1000 + 5 + i * BucketCount);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: key extremes, every mode, overwrite, full bucket, misses, mode 3
        send_request(MODE_GET, 31'd0, 32'd0);
        send_request(MODE_PUT, 31'd0, 32'h8000_0000);
        send_request(MODE_PUT, 31'h7fff_ffff, 32'h7fff_ffff);
        send_request(MODE_GET, 31'h7fff_ffff, 32'hffff_ffff);
        send_request(MODE_PUT, 31'd0, 32'hffff_ffff);
        send_request(MODE_GET, 31'd0, 32'd0);
        for (int i = 1; i <= 4; i++) send_request(MODE_PUT, 31'(i * BucketCount), 32'(i));
        send_request(MODE_PUT, 31'(5 * BucketCount), 32'h5a5a_5a5a);
        send_request(MODE_GET, 31'(5 * BucketCount), 32'd0);
        send_request(MODE_REMOVE, 31'(2 * BucketCount), 32'd0);
        send_request(MODE_REMOVE, 31'(2 * BucketCount), 32'd0);
        send_request(MODE_PUT, 31'(6 * BucketCount), 32'h1234_5678);
        send_request(MODE_GET, 31'(6 * BucketCount), 32'd0);
        send_request(MODE_GET, 31'(2 * BucketCount), 32'd0);
        send_request(MODE_UNUSED, 31'h5555_5555, 32'haaaa_aaaa);
        send_request(MODE_UNUSED, 31'h2aaa_aaaa, 32'h5555_5555);
        send_request(MODE_REMOVE, 31'h7fff_ffff, 32'd0);
        send_request(MODE_GET, 31'h7fff_ffff, 32'd0);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        drain();

        // random phases with different idling mixes
        send_idle_pct = 0;  recv_stall_pct = 0;  run_random(300);
        send_idle_pct = 70; recv_stall_pct = 0;  run_random(250);
        send_idle_pct = 0;  recv_stall_pct = 70; run_random(250);
        send_idle_pct = 26; recv_stall_pct = 26; run_random(250);
        // receiver holds off while the sender keeps pushing
        send_idle_pct = 0;  recv_stall_pct = 0;  hold_req = 1'b1;
        run_random(250);
        drain();

        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("hash_map_engine_top regression: pass");
        else
            $display("hash_map_engine_top regression: fail");
        $finish;
    end
endmodule

// File: files.f
sv/hme_pkg.sv
sv/hme_datapath.sv
sv/hme_ctrl.sv
sv/hash_map_engine_top.sv
verif/testbench.sv
